/* rtl/decimal_string_to_int32_macros.svh */
// Assertion macros shared by the decimal string parser checker.
`ifndef DECIMAL_STRING_TO_INT32_MACROS_SVH
`define DECIMAL_STRING_TO_INT32_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DS2I_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ds2i checker: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define DS2I_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ds2i checker: next-cycle implication failed");

`endif

/* rtl/ds2i_pkg.sv */
// Types and constants of the decimal string to int32 parser.
`timescale 1ns / 1ps

package ds2i_pkg;

	localparam int ACC_W = 34;
	localparam int CNT_W = 4;

	typedef enum logic [2:0] {
		PH_LEAD       = 3'd0,
		PH_ZSKIP_P    = 3'd1,
		PH_ZSKIP_N    = 3'd2,
		PH_ZSKIP_U    = 3'd3,
		PH_AFTER_PLUS = 3'd4,
		PH_DIGITS     = 3'd5,
		PH_TRAIL      = 3'd6,
		PH_INVALID    = 3'd7
	} phase_t;

	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	localparam logic [CNT_W-1:0] MAX_DIGITS  = 4'd10;
	localparam logic [CNT_W-1:0] OVER_DIGITS = 4'd11;

	localparam logic [ACC_W-1:0] POS_LIMIT = 34'd2147483647;
	localparam logic [ACC_W-1:0] NEG_LIMIT = 34'd2147483648;

endpackage

/* rtl/decimal_string_to_int32.sv */
// Top level of the streaming decimal string to signed 32-bit integer parser.
//
// Usage:
//  - Input channel (char_valid / char_stall): one ASCII character per
//    transaction, with last_char high on the final character of a string.
//  - Output channel (value_valid / value_stall): one transaction per string,
//    carrying the parsed signed value, or 0 for a malformed or out-of-range
//    string. Nothing is produced for characters with last_char low.
//  - Throughput: one character per cycle, sustained, while the receiver
//    does not stall. Each character passes through the input register,
//    then through the parse step; the last one of a string is registered
//    into the result register, which raises value_valid.
//  - Stall: when the result register holds an untaken result and
//    value_stall is high, the whole pipe freezes and char_stall goes high;
//    otherwise the next character is taken while the result is read.
//  - Reset (arst_n low): pipe and result register empty, parser back to
//    the leading-space phase with a cleared accumulator.
`timescale 1ns / 1ps

module decimal_string_to_int32 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	input  logic               last_char,
	output logic               value_valid,
	input  logic               value_stall,
	output logic signed [31:0] value
);

	// Result register
	logic               value_valid_q;
	logic signed [31:0] value_q;

	// Pipe advance: everything moves unless a held result is stalled.
	logic adv;
	assign adv        = !value_valid_q || !value_stall;
	assign char_stall = !adv;

	// Input register stage
	logic       valid_s1;
	logic       last_s1;
	logic [7:0] char_s1;

	// Parser state
	ds2i_pkg::phase_t                 phase_q;
	logic                             neg_q;
	logic [ds2i_pkg::ACC_W-1:0]       acc_q;
	logic [ds2i_pkg::CNT_W-1:0]       cnt_q;

	assign value_valid = value_valid_q;
	assign value       = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_s1 <= char_code;
			last_s1 <= last_char;
		end
	end

	// Next-state logic for the character held in the input register.
	ds2i_pkg::phase_t           ph_nx;
	logic                       neg_nx;
	logic [ds2i_pkg::ACC_W-1:0] acc_nx;
	logic [ds2i_pkg::CNT_W-1:0] cnt_nx;
	logic                       is_digit;
	logic [3:0]                 digit;
	logic                       take;
	logic [ds2i_pkg::ACC_W-1:0] acc_x10;

	assign is_digit = char_s1 inside {[ds2i_pkg::CHAR_ZERO:ds2i_pkg::CHAR_NINE]};
	assign digit    = 4'(char_s1 - ds2i_pkg::CHAR_ZERO);
	assign acc_x10  = (acc_q << 3) + (acc_q << 1);

	always_comb begin
		ph_nx  = phase_q;
		neg_nx = neg_q;
		acc_nx = acc_q;
		cnt_nx = cnt_q;
		take   = 1'b0;
		if (phase_q == ds2i_pkg::PH_INVALID) begin
			ph_nx = ds2i_pkg::PH_INVALID;
		end else if (char_s1 == ds2i_pkg::CHAR_SPACE) begin
			if (phase_q != ds2i_pkg::PH_LEAD)
				ph_nx = ds2i_pkg::PH_TRAIL;
		end else begin
			case (phase_q)
				ds2i_pkg::PH_LEAD: begin
					if (char_s1 == ds2i_pkg::CHAR_PLUS) begin
						ph_nx = ds2i_pkg::PH_ZSKIP_P;
					end else if (char_s1 == ds2i_pkg::CHAR_MINUS) begin
						neg_nx = 1'b1;
						ph_nx  = ds2i_pkg::PH_ZSKIP_N;
					end else if (char_s1 == ds2i_pkg::CHAR_ZERO) begin
						ph_nx = ds2i_pkg::PH_ZSKIP_U;
					end else if (is_digit) begin
						take = 1'b1;
					end else begin
						ph_nx = ds2i_pkg::PH_INVALID;
					end
				end
				ds2i_pkg::PH_ZSKIP_P: begin
					if (char_s1 == ds2i_pkg::CHAR_ZERO) begin
						ph_nx = phase_q;
					end else if (char_s1 == ds2i_pkg::CHAR_MINUS) begin
						neg_nx = 1'b1;
						ph_nx  = ds2i_pkg::PH_DIGITS;
					end else if (is_digit) begin
						take = 1'b1;
					end else begin
						ph_nx = ds2i_pkg::PH_INVALID;
					end
				end
				ds2i_pkg::PH_ZSKIP_N: begin
					if (char_s1 == ds2i_pkg::CHAR_ZERO) begin
						ph_nx = phase_q;
					end else if (is_digit) begin
						take = 1'b1;
					end else begin
						ph_nx = ds2i_pkg::PH_INVALID;
					end
				end
				ds2i_pkg::PH_ZSKIP_U: begin
					if (char_s1 == ds2i_pkg::CHAR_ZERO) begin
						ph_nx = phase_q;
					end else if (char_s1 == ds2i_pkg::CHAR_PLUS) begin
						ph_nx = ds2i_pkg::PH_AFTER_PLUS;
					end else if (char_s1 == ds2i_pkg::CHAR_MINUS) begin
						neg_nx = 1'b1;
						ph_nx  = ds2i_pkg::PH_DIGITS;
					end else if (is_digit) begin
						take = 1'b1;
					end else begin
						ph_nx = ds2i_pkg::PH_INVALID;
					end
				end
				ds2i_pkg::PH_AFTER_PLUS: begin
					if (char_s1 == ds2i_pkg::CHAR_MINUS) begin
						neg_nx = 1'b1;
						ph_nx  = ds2i_pkg::PH_DIGITS;
					end else if (is_digit) begin
						take = 1'b1;
					end else begin
						ph_nx = ds2i_pkg::PH_INVALID;
					end
				end
				ds2i_pkg::PH_DIGITS: begin
					if (is_digit)
						take = 1'b1;
					else
						ph_nx = ds2i_pkg::PH_INVALID;
				end
				default: begin
					// non-space after trailing spaces
					ph_nx = ds2i_pkg::PH_INVALID;
				end
			endcase
		end
		if (take) begin
			ph_nx = ds2i_pkg::PH_DIGITS;
			if (cnt_q < ds2i_pkg::MAX_DIGITS) begin
				acc_nx = acc_x10 + ds2i_pkg::ACC_W'(digit);
				cnt_nx = cnt_q + 4'd1;
			end else begin
				// saturate; accumulation stops
				cnt_nx = ds2i_pkg::OVER_DIGITS;
			end
		end
	end

	// Final value for a string that ends with this character.
	logic                       bad;
	logic [ds2i_pkg::ACC_W-1:0] limit;
	logic [31:0]                mag;
	logic [31:0]                result;

	assign limit = neg_nx ? ds2i_pkg::NEG_LIMIT : ds2i_pkg::POS_LIMIT;
	assign bad   = (ph_nx == ds2i_pkg::PH_INVALID) ||
	               (cnt_nx > ds2i_pkg::MAX_DIGITS) ||
	               ((cnt_nx == ds2i_pkg::MAX_DIGITS) && (acc_nx > limit));
	assign mag    = acc_nx[31:0];
	// 0 - 2^31 wraps to the most negative value, as wanted
	assign result = bad ? 32'd0 : (neg_nx ? (32'd0 - mag) : mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ds2i_pkg::PH_LEAD;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else if (adv && valid_s1) begin
			if (last_s1) begin
				// string done: back to the reset state
				phase_q <= ds2i_pkg::PH_LEAD;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				cnt_q   <= '0;
			end else begin
				phase_q <= ph_nx;
				neg_q   <= neg_nx;
				acc_q   <= acc_nx;
				cnt_q   <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid_q <= 1'b0;
		end else if (adv) begin
			value_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && last_s1) begin
			value_q <= $signed(result);
		end
	end

endmodule

/* rtl/ds2i_checker.sv */
// Port-level checker for the decimal string parser, with its bind.
`timescale 1ns / 1ps
`include "decimal_string_to_int32_macros.svh"

module ds2i_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_stall,
	input logic [7:0]         char_code,
	input logic               last_char,
	input logic               value_valid,
	input logic               value_stall,
	input logic signed [31:0] value
);

	// A held result stays put while stalled.
	`DS2I_ASSERT_NXT(a_hold, clk, arst_n, value_valid && value_stall, value_valid && $stable(value))

	// The input side only stalls behind a stalled result.
	`DS2I_ASSERT_IMP(a_stall_src, clk, arst_n, char_stall, value_valid && value_stall)

	// A fresh result comes from an accepted last character that passed through the input register.
	`DS2I_ASSERT_IMP(a_result_src, clk, arst_n, $rose(value_valid), $past(char_valid && !char_stall && last_char, 2))

endmodule

bind decimal_string_to_int32 ds2i_checker u_ds2i_checker (.*);

/* test/decimal_string_to_int32_tb.sv */
// Self-checking testbench for the streaming decimal string to int32 parser.
`timescale 1ns / 1ps

module decimal_string_to_int32_tb;

	typedef bit [7:0] char_q_t[$];

	localparam int CLK_HALF    = 6;
	localparam int RESET_LEN   = 8;
	localparam int CHAR_BUDGET = 1400;
	// The limit covers the slowest legal run: ~1.5k characters, each behind
	// the longest sender gap and a full receiver stall.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 6;

	// Parse predictor and result checker. The parse state mirrors the block:
	// phase, sign, ten-digit accumulator and a saturating digit count.
	class int32_scoreboard;
		ds2i_pkg::phase_t               phase;
		bit                             negative;
		bit [ds2i_pkg::ACC_W-1:0]       acc;
		bit [ds2i_pkg::CNT_W-1:0]       ndigits;
		logic signed [31:0]             pending_values[$];
		int                             errors;
		int                             strings;
		int                             zero_results;
		int                             negative_results;

		function new();
			clear_parse();
			errors = 0;
			strings = 0;
			zero_results = 0;
			negative_results = 0;
		endfunction

		function void clear_parse();
			phase = ds2i_pkg::PH_LEAD;
			negative = 1'b0;
			acc = '0;
			ndigits = '0;
		endfunction

		function void add_digit(bit [3:0] d);
			if (ndigits < ds2i_pkg::MAX_DIGITS) begin
				acc = acc * 34'd10 + {30'b0, d};
				ndigits = ndigits + 1'b1;
			end else begin
				ndigits = ds2i_pkg::OVER_DIGITS;
			end
			phase = ds2i_pkg::PH_DIGITS;
		endfunction

		function void parse_char(bit [7:0] c);
			bit       is_digit;
			bit [3:0] d;
			is_digit = (c >= ds2i_pkg::CHAR_ZERO) && (c <= ds2i_pkg::CHAR_NINE);
			d = 4'(c - ds2i_pkg::CHAR_ZERO);
			if (phase == ds2i_pkg::PH_INVALID)
				return;
			if (c == ds2i_pkg::CHAR_SPACE) begin
				if (phase != ds2i_pkg::PH_LEAD)
					phase = ds2i_pkg::PH_TRAIL;
				return;
			end
			case (phase)
				ds2i_pkg::PH_LEAD: begin
					if (c == ds2i_pkg::CHAR_PLUS)
						phase = ds2i_pkg::PH_ZSKIP_P;
					else if (c == ds2i_pkg::CHAR_MINUS) begin
						negative = 1'b1;
						phase = ds2i_pkg::PH_ZSKIP_N;
					end else if (c == ds2i_pkg::CHAR_ZERO)
						phase = ds2i_pkg::PH_ZSKIP_U;
					else if (is_digit)
						add_digit(d);
					else
						phase = ds2i_pkg::PH_INVALID;
				end
				ds2i_pkg::PH_ZSKIP_P: begin
					if (c == ds2i_pkg::CHAR_MINUS) begin
						negative = 1'b1;
						phase = ds2i_pkg::PH_DIGITS;
					end else if (is_digit) begin
						if (c != ds2i_pkg::CHAR_ZERO)
							add_digit(d);
					end else
						phase = ds2i_pkg::PH_INVALID;
				end
				ds2i_pkg::PH_ZSKIP_N: begin
					if (is_digit) begin
						if (c != ds2i_pkg::CHAR_ZERO)
							add_digit(d);
					end else
						phase = ds2i_pkg::PH_INVALID;
				end
				ds2i_pkg::PH_ZSKIP_U: begin
					if (c == ds2i_pkg::CHAR_PLUS)
						phase = ds2i_pkg::PH_AFTER_PLUS;
					else if (c == ds2i_pkg::CHAR_MINUS) begin
						negative = 1'b1;
						phase = ds2i_pkg::PH_DIGITS;
					end else if (is_digit) begin
						if (c != ds2i_pkg::CHAR_ZERO)
							add_digit(d);
					end else
						phase = ds2i_pkg::PH_INVALID;
				end
				ds2i_pkg::PH_AFTER_PLUS: begin
					if (c == ds2i_pkg::CHAR_MINUS) begin
						negative = 1'b1;
						phase = ds2i_pkg::PH_DIGITS;
					end else if (is_digit)
						add_digit(d);
					else
						phase = ds2i_pkg::PH_INVALID;
				end
				ds2i_pkg::PH_DIGITS: begin
					if (is_digit)
						add_digit(d);
					else
						phase = ds2i_pkg::PH_INVALID;
				end
				default: phase = ds2i_pkg::PH_INVALID;
			endcase
		endfunction

		function logic signed [31:0] parsed_value();
			bit [ds2i_pkg::ACC_W-1:0] limit;
			limit = negative ? ds2i_pkg::NEG_LIMIT : ds2i_pkg::POS_LIMIT;
			if (phase == ds2i_pkg::PH_INVALID || ndigits > ds2i_pkg::MAX_DIGITS)
				return '0;
			if (ndigits == ds2i_pkg::MAX_DIGITS && acc > limit)
				return '0;
			if (negative)
				return -acc[31:0];
			return acc[31:0];
		endfunction

		// Called for every accepted character; the last one queues a result.
		function void note_char(bit [7:0] c, bit last);
			logic signed [31:0] v;
			parse_char(c);
			if (last) begin
				v = parsed_value();
				pending_values = {pending_values, v};
				strings++;
				if (v == 0)
					zero_results++;
				if (v < 0)
					negative_results++;
				clear_parse();
			end
		endfunction

		function void check_value(logic signed [31:0] got);
			logic signed [31:0] want;
			if (pending_values.size() == 0) begin
				$display("%0t: unexpected value transaction: expected none, got %0d",
					$time, got);
				errors++;
				return;
			end
			want = pending_values[0];
			pending_values.delete(0);
			if (got !== want) begin
				$display("%0t: value mismatch: expected %0d, got %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	// DUT ports; every input starts at a known value.
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               char_valid = 1'b0;
	logic               char_stall;
	logic [7:0]         char_code = 8'd0;
	logic               last_char = 1'b0;
	logic               value_valid;
	logic               value_stall = 1'b0;
	logic signed [31:0] value;

	int32_scoreboard board;
	bit              tx_idle_on = 1'b0;
	bit              rx_idle_on = 1'b0;
	int              chars_sent = 0;
	int              cycle_count = 0;
	int              stall_left = 0;

	decimal_string_to_int32 DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_code   (char_code),
		.last_char   (last_char),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value)
	);

	always #CLK_HALF clk = ~clk;

	// Idle length: mostly none or short, now and then a long one.
	function automatic int pick_gap(bit enable);
		int r;
		if (!enable)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic char_q_t from_text(string t);
		char_q_t s;
		for (int i = 0; i < t.len(); i++)
			s = {s, t[i]};
		return s;
	endfunction

	function automatic bit [7:0] rand_digit();
		return 8'(ds2i_pkg::CHAR_ZERO + $urandom_range(0, 9));
	endfunction

	// Mostly well-formed numbers with random sign forms, padding and lengths;
	// some near the int32 limits, plus junk bytes and damaged strings.
	function automatic char_q_t random_string();
		char_q_t s;
		int      kind;
		int      n;
		int      pos;
		kind = $urandom_range(0, 99);
		if (kind < 4) begin
			n = $urandom_range(1, 6);
			repeat (n) s = {s, 8'($urandom_range(0, 255))};
			return s;
		end
		if (kind < 6) begin
			n = $urandom_range(1, 4);
			repeat (n) s = {s, ds2i_pkg::CHAR_SPACE};
			return s;
		end
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) s = {s, ds2i_pkg::CHAR_SPACE};
		case ($urandom_range(0, 11))
			4, 5: s = {s, ds2i_pkg::CHAR_MINUS};
			6: s = {s, ds2i_pkg::CHAR_PLUS};
			7: s = {s, ds2i_pkg::CHAR_PLUS, ds2i_pkg::CHAR_MINUS};
			8: s = {s, ds2i_pkg::CHAR_ZERO, ds2i_pkg::CHAR_PLUS, ds2i_pkg::CHAR_MINUS};
			9: s = {s, ds2i_pkg::CHAR_ZERO, ds2i_pkg::CHAR_MINUS};
			10: s = {s, ds2i_pkg::CHAR_ZERO, ds2i_pkg::CHAR_PLUS};
			11: s = {s, ds2i_pkg::CHAR_PLUS, ds2i_pkg::CHAR_ZERO, ds2i_pkg::CHAR_MINUS};
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) s = {s, ds2i_pkg::CHAR_ZERO};
		end
		kind = $urandom_range(0, 99);
		if (kind < 3)
			n = 0;
		else if (kind < 55)
			n = $urandom_range(1, 5);
		else if (kind < 75)
			n = $urandom_range(6, 9);
		else if (kind < 92)
			n = 10;
		else
			n = $urandom_range(11, 13);
		if (n == 10 && $urandom_range(0, 1) == 1) begin
			// straddle the limits
			s = {s, from_text("214748364")};
			s = {s, 8'(ds2i_pkg::CHAR_ZERO + $urandom_range(6, 9))};
		end else begin
			repeat (n) s = {s, rand_digit()};
		end
		n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) s = {s, ds2i_pkg::CHAR_SPACE};
		if (s.size() == 0)
			s = {s, rand_digit()};
		// damage about one string in seven
		if ($urandom_range(0, 6) == 0) begin
			pos = $urandom_range(0, s.size() - 1);
			case ($urandom_range(0, 2))
				0: s[pos] = 8'($urandom_range(0, 255));
				1: s.insert(pos, ds2i_pkg::CHAR_SPACE);
				default: s.insert(pos, ($urandom_range(0, 1) == 1) ?
					ds2i_pkg::CHAR_PLUS : ds2i_pkg::CHAR_MINUS);
			endcase
		end
		return s;
	endfunction

	// Send one string, one character per transaction, with optional gaps.
	task automatic send_string(input char_q_t s);
		int gap;
		bit last;
		for (int i = 0; i < s.size(); i++) begin
			last = (i == s.size() - 1);
			gap = pick_gap(tx_idle_on);
			if (gap > 0) begin
				char_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			char_valid <= 1'b1;
			char_code <= s[i];
			last_char <= last;
			@(posedge clk);
			while (char_stall)
				@(posedge clk);
			board.note_char(s[i], last);
			chars_sent++;
		end
	endtask

	task automatic send_text(input string t);
		send_string(from_text(t));
	endtask

	// Sender holds off until every queued result has come back.
	task automatic wait_drained();
		char_valid <= 1'b0;
		while (board.pending_values.size() != 0)
			@(posedge clk);
	endtask

	// Result side: check every accepted value, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n && value_valid && !value_stall)
			board.check_value(value);
		if (stall_left > 0) begin
			stall_left--;
			value_stall <= 1'b1;
		end else begin
			value_stall <= 1'b0;
			if (rx_idle_on && $urandom_range(0, 3) == 0)
				stall_left = pick_gap(1'b1);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		char_q_t raw;
		int      seg_end;
		board = new();
		repeat (RESET_LEN) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings: limits, sign forms, padding, bad characters.
		send_text("0");
		send_text("7");
		send_text("2147483647");
		send_text("-2147483648");
		send_text("2147483648");
		send_text("-2147483649");
		send_text("9999999999");
		send_text("12345678901");
		send_text("0000000002147483647");
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_text("+-12");
		send_text("+-0000000001");
		send_text("0+-005");
		send_text("+0-3");
		send_text("0-7");
		send_text("+007");
		send_text("-0");
		send_text("   42  ");
		send_text("   ");
		send_text("+");
		send_text("-");
		send_text("0+-");
		send_text("4 2");
		send_text("12a");
		raw = {8'hFF};
		send_string(raw);
		raw = {ds2i_pkg::CHAR_SPACE, 8'h00};
		send_string(raw);

		// Random strings in segments that vary who idles; a full drain of
		// the result side is forced midway.
		for (int seg = 0; seg < 6; seg++) begin
			tx_idle_on = (seg != 0) && (seg != 2);
			rx_idle_on = (seg >= 2);
			if (seg == 3)
				wait_drained();
			seg_end = (CHAR_BUDGET * (seg + 1)) / 6;
			while (chars_sent < seg_end)
				send_string(random_string());
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Sent %0d strings in %0d characters: %0d zero results, %0d negative.",
			board.strings, chars_sent, board.zero_results, board.negative_results);
		$display("Checked %0d mismatches over sign forms, limits and idle patterns.",
			board.errors);
		if (board.errors == 0 && board.pending_values.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* decimal_string_to_int32.f */
+incdir+rtl
rtl/ds2i_pkg.sv
rtl/decimal_string_to_int32.sv
rtl/ds2i_checker.sv
test/decimal_string_to_int32_tb.sv
